// File: sv/ipk_pkg.sv
// Package for the iambic paddle keyer.
// Holds timer width, register indexes and the shared structs; depends on nothing.
package ipk_pkg;

   localparam int TIMER_BITS = 12;
   localparam int DIT_W      = 10;
   localparam int PHASE_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CMP_W      = (TIMER_BITS > 12) ? TIMER_BITS : 12;

   localparam logic [CSR_IDX_W-1:0] CSR_DIT_TIME     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_PADDLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_MODE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IAMBIC_B     = 2'd3;

   localparam logic [DIT_W-1:0] DIT_TIME_RESET = 10'd100;

   typedef struct packed {
      logic [DIT_W-1:0] dit_time;
      logic             swap_paddles;
      logic             single_mode;
      logic             iambic_b;
   } ipk_cfg_type;

   typedef struct packed {
      logic               dit_pressed;
      logic               dah_pressed;
      logic               ms_tick;
      logic               hold;
   } ipk_item_type;

   typedef struct packed {
      logic               key_level;
      logic [PHASE_W-1:0] keyer_phase;
   } ipk_result_type;

endpackage

// File: sv/ipk_core.sv
// Keyer state machine: paddle latches, millisecond counter and phase sequencing.
// Depends on ipk_pkg for the timer width and the item, result and config structs.
module ipk_core
   import ipk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  ipk_item_type   item,
   input  ipk_cfg_type    cfg,
   output ipk_result_type result
);

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE    = 3'd0,
      PH_CHK_DIT = 3'd1,
      PH_CHK_DAH = 3'd2,
      PH_PREP    = 3'd3,
      PH_KEYED   = 3'd4,
      PH_GAP     = 3'd5
   } phase_type;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic                  dit_latch_ff, dit_latch_in;
   logic                  dah_latch_ff, dah_latch_in;
   logic                  dit_prog_ff, dit_prog_in;
   logic                  last_dah_ff, last_dah_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic                  key_line_ff, key_line_in;

   logic [DIT_W-1:0]      half_dit;
   logic [DIT_W:0]        sum_thr;
   logic [DIT_W:0]        keyed_thr;
   logic [DIT_W:0]        dit_x2;
   logic [DIT_W+1:0]      dit_x3;
   logic [TIMER_BITS-1:0] elapsed_tick;
   logic [CMP_W-1:0]      elapsed_cmp;
   logic                  dit_set;
   logic                  dah_set;
   logic                  dit_l;
   logic                  dah_l;

   always_comb begin
      half_dit  = {1'b0, cfg.dit_time[DIT_W-1:1]};
      sum_thr   = {1'b0, cfg.dit_time} + {1'b0, half_dit};
      keyed_thr = (sum_thr < (DIT_W+1)'(2)) ? '0 : sum_thr - (DIT_W+1)'(2);
      dit_x2    = {cfg.dit_time, 1'b0};
      dit_x3    = {2'b00, cfg.dit_time} + {1'b0, cfg.dit_time, 1'b0};
   end

   always_comb begin
      phase_in     = phase_ff;
      dit_latch_in = dit_latch_ff;
      dah_latch_in = dah_latch_ff;
      dit_prog_in  = dit_prog_ff;
      last_dah_in  = last_dah_ff;
      elapsed_in   = elapsed_ff;
      key_line_in  = key_line_ff;

      elapsed_tick = (item.ms_tick && (elapsed_ff != TIMER_MAX)) ?
                     elapsed_ff + TIMER_BITS'(1) : elapsed_ff;
      elapsed_cmp  = CMP_W'(elapsed_tick);

      dit_set = cfg.swap_paddles ? item.dah_pressed : item.dit_pressed;
      dah_set = cfg.swap_paddles ? item.dit_pressed : item.dah_pressed;
      dit_l   = dit_latch_ff | dit_set;
      dah_l   = dah_latch_ff | dah_set;

      if (!item.hold) begin
         elapsed_in   = elapsed_tick;
         dit_latch_in = dit_l;
         dah_latch_in = dah_l;
         case (phase_ff)
            PH_CHK_DIT: begin
               if (dit_l) begin
                  phase_in = PH_PREP;
               end else if (dah_l) begin
                  phase_in = PH_CHK_DAH;
               end else if (elapsed_cmp > CMP_W'(half_dit)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CHK_DAH: begin
               if (dah_l) begin
                  phase_in = PH_PREP;
               end else if (dit_l) begin
                  phase_in = PH_CHK_DIT;
               end else if (elapsed_cmp > CMP_W'(dit_x2)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PREP: begin
               elapsed_in = '0;
               if (dit_l) begin
                  dit_prog_in  = 1'b1;
                  dit_latch_in = 1'b0;
                  last_dah_in  = 1'b0;
               end else if (dah_l) begin
                  dah_latch_in = 1'b0;
                  last_dah_in  = 1'b1;
               end
               phase_in = PH_KEYED;
            end
            PH_KEYED: begin
               if (elapsed_cmp > CMP_W'(keyed_thr)) begin
                  key_line_in = 1'b1;
                  dit_prog_in = 1'b0;
                  phase_in    = PH_GAP;
                  elapsed_in  = '0;
               end else begin
                  key_line_in = 1'b0;
               end
            end
            PH_GAP: begin
               if (cfg.single_mode) begin
                  phase_in = PH_IDLE;
               end else if (dit_prog_ff) begin
                  phase_in = PH_CHK_DIT;
               end else if (dit_l || dah_l) begin
                  if (cfg.iambic_b) begin
                     if (dit_l) begin
                        dit_prog_in  = 1'b1;
                        dit_latch_in = 1'b0;
                     end
                     dah_latch_in = 1'b0;
                  end
                  phase_in = PH_CHK_DIT;
               end else if (last_dah_ff) begin
                  if (elapsed_cmp > CMP_W'(dit_x3)) begin
                     phase_in = PH_IDLE;
                  end
               end else begin
                  if (elapsed_cmp > CMP_W'(cfg.dit_time)) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in    = (dit_l || dah_l) ? PH_PREP : PH_IDLE;
               key_line_in = 1'b1;
               elapsed_in  = '0;
            end
         endcase
      end

      result.key_level   = key_line_in;
      result.keyer_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         dit_latch_ff <= 1'b0;
         dah_latch_ff <= 1'b0;
         dit_prog_ff  <= 1'b0;
         last_dah_ff  <= 1'b0;
         elapsed_ff   <= '0;
         key_line_ff  <= 1'b1;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         dit_latch_ff <= dit_latch_in;
         dah_latch_ff <= dah_latch_in;
         dit_prog_ff  <= dit_prog_in;
         last_dah_ff  <= last_dah_in;
         elapsed_ff   <= elapsed_in;
         key_line_ff  <= key_line_in;
      end
   end

   a_key_only_when_keyed: assert property (@(posedge clock) disable iff (reset)
      !key_line_ff |-> (phase_ff == PH_KEYED))
      else $error("key line active outside the keyed phase");

   a_hold_freezes: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.hold) |=> ($stable(phase_ff) && $stable(elapsed_ff)
                                  && $stable(key_line_ff)))
      else $error("held step changed the keyer state");

   a_prep_to_keyed: assert property (@(posedge clock) disable iff (reset)
      (step_en && !item.hold && (phase_ff == PH_PREP))
      |=> ((phase_ff == PH_KEYED) && (elapsed_ff == '0)))
      else $error("prep phase did not restart the timer and enter keyed");

endmodule

// File: sv/iambic_paddle_keyer_unit.sv
// Iambic paddle keyer: request/response channels, configuration registers, output skid.
// Depends on ipk_pkg and instantiates ipk_core.
//
// Each transfer on the req_ channel carries one paddle sample: both paddle
// contacts, a flag that one millisecond has passed, and a hold flag that
// freezes the keyer. Every sample yields exactly one transfer on the rsp_
// channel with the key line level and the current keyer phase.
// The sample is evaluated in the cycle it is accepted and the result is
// registered in the output register, or in the skid register on a stall.
// Throughput is one sample per cycle while req_ready is high; ipk_core
// updates its state on every accepted sample.
// When the receiver stalls, one further result is parked in a skid register
// and req_ready then drops until the output register drains.
// Configuration is written through csr_we, csr_index and csr_wdata, one
// register per cycle, and takes effect on the next sample; the user must
// write it only while no transfer is outstanding, as the block does not enforce it.
// Synchronous reset returns the keyer to idle with the key released, the
// timer cleared, the dit time at 100 ms and all mode bits off.
module iambic_paddle_keyer_unit
   import ipk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_dit_pressed,
   input  logic                 req_dah_pressed,
   input  logic                 req_ms_tick,
   input  logic                 req_hold,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_key_level,
   output logic [PHASE_W-1:0]   rsp_keyer_phase,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIT_W-1:0]     csr_wdata
);

   ipk_cfg_type    cfg_ff;
   ipk_item_type   item;
   ipk_result_type step_result;
   ipk_result_type out_ff;
   ipk_result_type skid_ff;
   logic           out_valid_ff;
   logic           skid_valid_ff;
   logic           accept;
   logic           out_free;

   assign item.dit_pressed = req_dit_pressed;
   assign item.dah_pressed = req_dah_pressed;
   assign item.ms_tick     = req_ms_tick;
   assign item.hold        = req_hold;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dit_time     <= DIT_TIME_RESET;
         cfg_ff.swap_paddles <= 1'b0;
         cfg_ff.single_mode  <= 1'b0;
         cfg_ff.iambic_b     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIT_TIME:     cfg_ff.dit_time     <= csr_wdata;
            CSR_SWAP_PADDLES: cfg_ff.swap_paddles <= csr_wdata[0];
            CSR_SINGLE_MODE:  cfg_ff.single_mode  <= csr_wdata[0];
            CSR_IAMBIC_B:     cfg_ff.iambic_b     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ipk_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (item),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= step_result;
         end
      end else if (accept) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_level   = out_ff.key_level;
   assign rsp_keyer_phase = out_ff.keyer_phase;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted transfer left no result in the output register");

endmodule

// File: tb/sv/tb_iambic_paddle_keyer_unit.sv
// Self-checking testbench for iambic_paddle_keyer_unit: paddle samples in, key and phase out.
// A scoreboard class predicts every response and compares it field by field.
// Depends on ipk_pkg and the keyer RTL only.
module tb_iambic_paddle_keyer_unit;
   import ipk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 20;

   typedef enum logic [PHASE_W-1:0] {
      KP_IDLE      = 3'd0,
      KP_CHECK_DIT = 3'd1,
      KP_CHECK_DAH = 3'd2,
      KP_PREP      = 3'd3,
      KP_KEYED     = 3'd4,
      KP_GAP       = 3'd5
   } keyer_phase_type;

   // Fields are dit, dah, tick, hold from left to right.
   localparam logic [3:0] OPENING_ITEMS [0:20] = '{
      4'b0000, 4'b1111, 4'b0010, 4'b1000, 4'b0110, 4'b0011, 4'b0010,
      4'b0010, 4'b0010, 4'b0110, 4'b0010, 4'b0010, 4'b0000, 4'b0010,
      4'b0010, 4'b1110, 4'b0010, 4'b0010, 4'b0010, 4'b0010, 4'b0000
   };

   class keyer_scoreboard_type;
      ipk_cfg_type              cfg;
      keyer_phase_type          phase;
      bit                       dit_latch;
      bit                       dah_latch;
      bit                       dit_in_progress;
      bit                       last_was_dah;
      bit                       key_line;
      logic [TIMER_BITS-1:0]    elapsed_ms;
      ipk_result_type           expected_q[$];
      int                       failures;

      function new();
         cfg.dit_time     = DIT_TIME_RESET;
         cfg.swap_paddles = 1'b0;
         cfg.single_mode  = 1'b0;
         cfg.iambic_b     = 1'b0;
         phase            = KP_IDLE;
         dit_latch        = 1'b0;
         dah_latch        = 1'b0;
         dit_in_progress  = 1'b0;
         last_was_dah     = 1'b0;
         key_line         = 1'b1;
         elapsed_ms       = '0;
         failures         = 0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx, input logic [DIT_W-1:0] data);
         case (idx)
            CSR_DIT_TIME:     cfg.dit_time     = data;
            CSR_SWAP_PADDLES: cfg.swap_paddles = data[0];
            CSR_SINGLE_MODE:  cfg.single_mode  = data[0];
            CSR_IAMBIC_B:     cfg.iambic_b     = data[0];
            default: ;
         endcase
      endfunction

      function void capture_paddles(input bit dit_in, input bit dah_in);
         if (dit_in) begin
            if (cfg.swap_paddles) dah_latch = 1'b1;
            else dit_latch = 1'b1;
         end
         if (dah_in) begin
            if (cfg.swap_paddles) dit_latch = 1'b1;
            else dah_latch = 1'b1;
         end
      endfunction

      function void note_sample(input ipk_item_type s);
         int unsigned    dit;
         int unsigned    keyed_limit;
         ipk_result_type r;
         if (!s.hold) begin
            if (s.ms_tick && elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
            capture_paddles(s.dit_pressed, s.dah_pressed);
            dit = cfg.dit_time;
            keyed_limit = (dit + dit / 2 >= 2) ? dit + dit / 2 - 2 : 0;
            case (phase)
               KP_CHECK_DIT: begin
                  if (dit_latch) phase = KP_PREP;
                  else if (dah_latch) phase = KP_CHECK_DAH;
                  else if (elapsed_ms > dit / 2) phase = KP_IDLE;
               end
               KP_CHECK_DAH: begin
                  if (dah_latch) phase = KP_PREP;
                  else if (dit_latch) phase = KP_CHECK_DIT;
                  else if (elapsed_ms > dit * 2) phase = KP_IDLE;
               end
               KP_PREP: begin
                  elapsed_ms = '0;
                  if (dit_latch) begin
                     dit_in_progress = 1'b1;
                     dit_latch = 1'b0;
                     last_was_dah = 1'b0;
                  end else if (dah_latch) begin
                     dah_latch = 1'b0;
                     last_was_dah = 1'b1;
                  end
                  phase = KP_KEYED;
               end
               KP_KEYED: begin
                  if (elapsed_ms > keyed_limit) begin
                     key_line = 1'b1;
                     dit_in_progress = 1'b0;
                     phase = KP_GAP;
                     elapsed_ms = '0;
                  end else begin
                     key_line = 1'b0;
                  end
               end
               KP_GAP: begin
                  capture_paddles(s.dit_pressed, s.dah_pressed);
                  if (cfg.single_mode) begin
                     phase = KP_IDLE;
                  end else if (dit_in_progress) begin
                     phase = KP_CHECK_DIT;
                  end else if (dit_latch || dah_latch) begin
                     if (cfg.iambic_b) begin
                        if (dit_latch) begin
                           dit_in_progress = 1'b1;
                           dit_latch = 1'b0;
                        end
                        dah_latch = 1'b0;
                     end
                     phase = KP_CHECK_DIT;
                  end else if (last_was_dah) begin
                     if (elapsed_ms > dit * 3) phase = KP_IDLE;
                  end else begin
                     if (elapsed_ms > dit) phase = KP_IDLE;
                  end
               end
               default: begin
                  if (dit_latch || dah_latch) phase = KP_PREP;
                  else phase = KP_IDLE;
                  key_line = 1'b1;
                  elapsed_ms = '0;
               end
            endcase
         end
         r.key_level   = key_line;
         r.keyer_phase = phase;
         expected_q.push_back(r);
      endfunction

      function void check_result(input ipk_result_type act);
         ipk_result_type exp_r;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: response with none expected: key_level %0d keyer_phase %0d",
                        $time, act.key_level, act.keyer_phase);
            return;
         end
         exp_r = expected_q.pop_front();
         if (act.key_level !== exp_r.key_level) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: key_level expected %0d actual %0d",
                        $time, exp_r.key_level, act.key_level);
         end
         if (act.keyer_phase !== exp_r.keyer_phase) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: keyer_phase expected %0d actual %0d",
                        $time, exp_r.keyer_phase, act.keyer_phase);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_dit_pressed;
   logic                 req_dah_pressed;
   logic                 req_ms_tick;
   logic                 req_hold;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_key_level;
   logic [PHASE_W-1:0]   rsp_keyer_phase;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIT_W-1:0]     csr_wdata;

   keyer_scoreboard_type sb;
   int                   cycle_count = 0;
   int                   stall_mode = 0;
   int                   stall_left = 0;

   iambic_paddle_keyer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_dit_pressed (req_dit_pressed),
      .req_dah_pressed (req_dah_pressed),
      .req_ms_tick     (req_ms_tick),
      .req_hold        (req_hold),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_level   (rsp_key_level),
      .rsp_keyer_phase (rsp_keyer_phase),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("iambic_paddle_keyer_unit test failed");
         $finish;
      end
   end

   // The receiver alternates between always ready, random stalls and long stalls.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(8, 40);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      ipk_item_type   s;
      ipk_result_type r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            s.dit_pressed = req_dit_pressed;
            s.dah_pressed = req_dah_pressed;
            s.ms_tick     = req_ms_tick;
            s.hold        = req_hold;
            sb.note_sample(s);
         end
         if (rsp_valid && rsp_ready) begin
            r.key_level   = rsp_key_level;
            r.keyer_phase = rsp_keyer_phase;
            sb.check_result(r);
         end
      end
   end

   task automatic send_sample(input ipk_item_type s);
      req_valid       <= 1'b1;
      req_dit_pressed <= s.dit_pressed;
      req_dah_pressed <= s.dah_pressed;
      req_ms_tick     <= s.ms_tick;
      req_hold        <= s.hold;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic configure(input int dit, input bit swap, input bit single, input bit iambic);
      write_reg(CSR_DIT_TIME, DIT_W'(dit));
      write_reg(CSR_SWAP_PADDLES, DIT_W'(swap));
      write_reg(CSR_SINGLE_MODE, DIT_W'(single));
      write_reg(CSR_IAMBIC_B, DIT_W'(iambic));
      csr_we <= 1'b0;
   endtask

   task automatic send_opening(input int first, input int last);
      for (int i = first; i <= last; i++) send_sample(ipk_item_type'(OPENING_ITEMS[i]));
   endtask

   // Paddles are held down for runs of samples, as an operator would, with some noise.
   task automatic run_keying(input int count, input int tick_pct);
      ipk_item_type s;
      int           sent;
      int           burst;
      bit           dit_down;
      bit           dah_down;
      sent = 0;
      dit_down = 1'b0;
      dah_down = 1'b0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            if ($urandom_range(0, 7) == 0) dit_down = !dit_down;
            if ($urandom_range(0, 9) == 0) dah_down = !dah_down;
            s.dit_pressed = dit_down;
            s.dah_pressed = dah_down;
            if ($urandom_range(0, 9) == 0) begin
               s.dit_pressed = 1'($urandom_range(0, 1));
               s.dah_pressed = 1'($urandom_range(0, 1));
            end
            s.ms_tick = ($urandom_range(0, 99) < tick_pct);
            s.hold    = ($urandom_range(0, 24) == 0);
            send_sample(s);
            if (!s.hold) sent++;
         end
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_dit_pressed = 1'b0;
      req_dah_pressed = 1'b0;
      req_ms_tick     = 1'b0;
      req_hold        = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_opening(0, 6);
      wait_idle(4);
      configure(2, 1'b0, 1'b0, 1'b0);
      send_opening(7, 20);
      wait_idle(4);

      run_keying(90, 80);
      wait_idle(0);
      run_keying(70, 60);
      wait_idle(4);
      configure(3, 1'b1, 1'b0, 1'b1);
      run_keying(140, 75);
      wait_idle(4);
      configure(1023, 1'b0, 1'b1, 1'b0);
      run_keying(60, 100);
      wait_idle(4);
      configure(5, 1'b0, 1'b1, 1'b1);
      run_keying(100, 85);
      wait_idle(4);
      configure(4, 1'b1, 1'b0, 1'b1);
      run_keying(120, 70);
      wait_idle(4);
      configure($urandom_range(2, 12), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      run_keying(100, 80);
      wait_idle(10);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("iambic_paddle_keyer_unit test passed");
      end else begin
         $display("iambic_paddle_keyer_unit test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/ipk_pkg.sv
sv/ipk_core.sv
sv/iambic_paddle_keyer_unit.sv
tb/sv/tb_iambic_paddle_keyer_unit.sv
